// ===== rtl/core/running_median_two_heaps_defines.svh =====
// assertion macros for the running median block
`ifndef RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_DEFINES_SVH
// a condition that must hold at every clock edge outside reset
`define RMH_ASSERT_ALWAYS(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("check failed");
// an antecedent that must lead to a consequent on the next edge
`define RMH_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// ===== rtl/core/rmh_pkg.sv =====
// shared types and constants for the running median block
`timescale 1ns / 1ps
package rmh_pkg;
    localparam int MaxSamples = 1024;
    localparam int HeapDepth  = (MaxSamples + 1) / 2;
    localparam int AddrW      = $clog2(HeapDepth);
    localparam int CntW       = $clog2(HeapDepth + 1);
    localparam int TotW       = $clog2(MaxSamples + 1);

    typedef struct packed {
        logic signed [31:0] sample;
        logic               start_of_run;
    } rmh_in_t;

    typedef struct packed {
        logic signed [31:0] median;
        logic signed [63:0] median_total;
        logic [10:0]        samples_seen;
        logic               full_dropped;
    } rmh_out_t;

    // heap operation request from the control loop to a heap unit
    typedef enum logic [1:0] {
        HOP_NONE,
        HOP_PUSH,
        HOP_REPLACE
    } rmh_op_t;

    typedef struct packed {
        rmh_op_t            op;
        logic signed [31:0] value;
        logic               clear;
    } rmh_heap_req_t;

    typedef struct packed {
        logic               busy;
        logic signed [31:0] top;
        logic [CntW-1:0]    count;
    } rmh_heap_stat_t;
endpackage

// ===== rtl/core/running_median_two_heaps.sv =====
// Running lower median over signed samples, kept in a max-heap and a min-heap.
// A sample dropped at capacity keeps busy high for one cycle. Every heap level
// waits on a registered memory read: a push takes a read and a compare state per
// level, a replace of the top reads the children and then compares, and a
// replace is always followed by a push into the other heap. busy is high from
// the cycle after the transfer through the result strobe; median, median_total,
// samples_seen and full_dropped are valid for the single cycle of done and must
// be taken then, as the block cannot be stalled.
`timescale 1ns / 1ps
`include "running_median_two_heaps_defines.svh"
module running_median_two_heaps import rmh_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rmh_in_t  in_data,
    output logic     done,
    output rmh_out_t result
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_WAIT2,
        S_SUM,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic signed [31:0] x_reg;
    logic signed [31:0] t_reg;
    logic [1:0]         path_reg;
    logic signed [63:0] sum_reg;
    logic [TotW-1:0]    total_reg;
    logic               drop_reg;
    logic               clr_pending;

    rmh_heap_req_t  lo_req, up_req;
    rmh_heap_stat_t lo_st, up_st;

    localparam logic [1:0] P_LO_PUSH = 2'd0;
    localparam logic [1:0] P_LO_SWAP = 2'd1;
    localparam logic [1:0] P_UP_PUSH = 2'd2;
    localparam logic [1:0] P_UP_SWAP = 2'd3;

    rmh_heap u_lo (.clk(clk), .rst_n(rst_n), .is_max(1'b1), .req(lo_req), .stat(lo_st));
    rmh_heap u_up (.clk(clk), .rst_n(rst_n), .is_max(1'b0), .req(up_req), .stat(up_st));

    logic go_low, heaps_idle, lo_empty;
    assign heaps_idle = !lo_st.busy && !up_st.busy;
    assign lo_empty   = (lo_st.count == '0);
    assign go_low     = lo_empty || (x_reg <= lo_st.top);

    always_comb
    begin
        lo_req = '{op: HOP_NONE, value: x_reg, clear: 1'b0};
        up_req = '{op: HOP_NONE, value: x_reg, clear: 1'b0};
        if (state_reg == S_IDLE && start && in_data.start_of_run)
        begin
            lo_req.clear = 1'b1;
            up_req.clear = 1'b1;
        end
        if (state_reg == S_FIRST)
        begin
            case (path_reg)
                P_LO_PUSH: lo_req.op = HOP_PUSH;
                P_LO_SWAP: lo_req.op = HOP_REPLACE;
                P_UP_PUSH: up_req.op = HOP_PUSH;
                P_UP_SWAP: up_req.op = HOP_REPLACE;
                default: ;
            endcase
        end
        if (state_reg == S_SECOND)
        begin
            if (path_reg == P_LO_SWAP)
            begin
                up_req.op = HOP_PUSH;
                up_req.value = t_reg;
            end
            else if (path_reg == P_UP_SWAP)
            begin
                lo_req.op = HOP_PUSH;
                lo_req.value = t_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sum_reg     <= '0;
            total_reg   <= '0;
            drop_reg    <= 1'b0;
            clr_pending <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= in_data.sample;
                        if (in_data.start_of_run)
                        begin
                            sum_reg   <= '0;
                            total_reg <= '0;
                            drop_reg  <= 1'b0;
                            state_reg <= S_SECOND;
                            path_reg  <= P_LO_PUSH;
                            clr_pending <= 1'b1;
                        end
                        else if (total_reg >= TotW'(MaxSamples))
                        begin
                            drop_reg  <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            drop_reg  <= 1'b0;
                            clr_pending <= 1'b1;
                            state_reg <= S_SECOND;
                            path_reg  <= P_LO_PUSH;
                        end
                    end
                end
                S_SECOND:
                begin
                    if (clr_pending)
                    begin
                        // classify the sample against the current tops
                        clr_pending <= 1'b0;
                        state_reg   <= S_FIRST;
                        if (go_low)
                        begin
                            t_reg    <= lo_st.top;
                            path_reg <= (lo_st.count > up_st.count) ? P_LO_SWAP : P_LO_PUSH;
                        end
                        else if (up_st.count >= lo_st.count)
                        begin
                            if (up_st.count != '0 && x_reg > up_st.top)
                            begin
                                t_reg    <= up_st.top;
                                path_reg <= P_UP_SWAP;
                            end
                            else
                            begin
                                // sample goes straight to the lower heap
                                path_reg <= P_LO_PUSH;
                            end
                        end
                        else
                        begin
                            path_reg <= P_UP_PUSH;
                        end
                    end
                    else
                    begin
                        state_reg <= S_WAIT2;
                    end
                end
                S_FIRST:
                begin
                    state_reg <= S_WAIT2;
                    if (path_reg == P_LO_SWAP || path_reg == P_UP_SWAP)
                    begin
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    if (heaps_idle)
                    begin
                        state_reg <= S_SECOND;
                    end
                end
                S_WAIT2:
                begin
                    if (heaps_idle)
                    begin
                        total_reg <= total_reg + TotW'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!drop_reg)
                    begin
                        sum_reg <= sum_reg + 64'(lo_st.top);
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic signed [63:0] sum_out;
    assign sum_out = drop_reg ? sum_reg : sum_reg + 64'(lo_st.top);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign result.median       = lo_empty ? 32'sd0 : lo_st.top;
    assign result.median_total = sum_out;
    assign result.samples_seen = 11'(total_reg);
    assign result.full_dropped = drop_reg;

    `RMH_ASSERT_ALWAYS(a_count_bal, clk, rst_n,
        state_reg != S_IDLE || (lo_st.count == up_st.count || lo_st.count == up_st.count + 1'b1))
    `RMH_ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `RMH_ASSERT_ALWAYS(a_heaps_idle, clk, rst_n, state_reg != S_DONE || heaps_idle)
endmodule

// ===== rtl/core/rmh_heap.sv =====
// one binary heap held in a synchronous memory, push and replace-top with sift
`timescale 1ns / 1ps
module rmh_heap import rmh_pkg::*; (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           is_max,
    input  rmh_heap_req_t  req,
    output rmh_heap_stat_t stat
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP
    } state_t;

    logic signed [31:0] mem [HeapDepth];
    logic signed [31:0] rd_data;
    logic [AddrW-1:0]   rd_addr;
    logic               wr_en;
    logic [AddrW-1:0]   wr_addr;
    logic signed [31:0] wr_data;

    state_t             state_reg;
    logic [CntW-1:0]    count_reg;
    logic signed [31:0] top_reg;
    logic signed [31:0] val_reg;
    logic signed [31:0] lval_reg;
    logic [AddrW-1:0]   k_reg;
    logic               lok_reg;

    logic [CntW:0]      l_idx;
    logic [CntW:0]      r_idx;
    logic [AddrW-1:0]   p_idx;

    function automatic logic above(input logic mx, input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        above = mx ? (a > b) : (a < b);
    endfunction

    assign l_idx = {1'b0, k_reg, 1'b1};
    assign r_idx = {1'b0, k_reg, 1'b0} + (CntW+1)'(2);
    assign p_idx = (k_reg - AddrW'(1)) >> 1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // combinational memory controls
    always_comb
    begin
        rd_addr = p_idx;
        wr_en   = 1'b0;
        wr_addr = k_reg;
        wr_data = val_reg;
        case (state_reg)
            S_UP_RD:  rd_addr = p_idx;
            S_DN_RDL: rd_addr = l_idx[AddrW-1:0];
            S_DN_RDR: rd_addr = r_idx[AddrW-1:0];
            S_UP_CMP:
            begin
                if (k_reg != '0 && above(is_max, val_reg, rd_data))
                begin
                    wr_en = 1'b1;
                    wr_data = rd_data;
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            S_DN_CMP:
            begin
                wr_en = 1'b1;
                if (r_idx < (CntW+1)'(count_reg) && above(is_max, rd_data, val_reg)
                    && !(lok_reg && !above(is_max, rd_data, lval_reg)))
                begin
                    wr_data = rd_data;
                end
                else if (lok_reg && above(is_max, lval_reg, val_reg))
                begin
                    wr_data = lval_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.clear)
                    begin
                        count_reg <= '0;
                    end
                    else if (req.op == HOP_PUSH)
                    begin
                        val_reg   <= req.value;
                        k_reg     <= AddrW'(count_reg);
                        count_reg <= count_reg + CntW'(1);
                        state_reg <= S_UP_RD;
                    end
                    else if (req.op == HOP_REPLACE)
                    begin
                        val_reg   <= req.value;
                        k_reg     <= '0;
                        state_reg <= S_DN_RDL;
                    end
                end
                S_UP_RD: state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (k_reg != '0 && above(is_max, val_reg, rd_data))
                    begin
                        k_reg     <= p_idx;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        if (k_reg == '0)
                        begin
                            top_reg <= val_reg;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_DN_RDL:
                begin
                    if (l_idx >= (CntW+1)'(count_reg))
                    begin
                        // no children: value settles here
                        state_reg <= S_DN_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DN_RDR;
                    end
                end
                S_DN_RDR:
                begin
                    lval_reg  <= rd_data;
                    lok_reg   <= 1'b1;
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                begin
                    if (r_idx < (CntW+1)'(count_reg) && above(is_max, rd_data, val_reg)
                        && !(lok_reg && !above(is_max, rd_data, lval_reg)))
                    begin
                        if (k_reg == '0) top_reg <= rd_data;
                        k_reg     <= r_idx[AddrW-1:0];
                        lok_reg   <= 1'b0;
                        state_reg <= S_DN_RDL;
                    end
                    else if (lok_reg && above(is_max, lval_reg, val_reg))
                    begin
                        if (k_reg == '0) top_reg <= lval_reg;
                        k_reg     <= l_idx[AddrW-1:0];
                        lok_reg   <= 1'b0;
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        if (k_reg == '0) top_reg <= val_reg;
                        lok_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg == S_IDLE && req.op == HOP_REPLACE && !req.clear)
            begin
                lok_reg <= 1'b0;
            end
        end
    end

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.top   = top_reg;
    assign stat.count = count_reg;
endmodule

// ===== verif/running_median_two_heaps_tb.sv =====
// self-checking testbench for the running median block
`timescale 1ns / 1ps
module running_median_two_heaps_tb import rmh_pkg::*; ();

    localparam int IdleLimit = 20000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    rmh_in_t  in_data;
    logic     done;
    rmh_out_t result;

    running_median_two_heaps uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_data (in_data),
        .done    (done),
        .result  (result)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // predictor state: lower half as max-heap, upper half as min-heap
    logic signed [31:0] low_heap [HeapDepth];
    logic signed [31:0] up_heap [HeapDepth];
    int                 low_n;
    int                 up_n;
    logic [63:0]        med_sum;
    int                 n_taken;
    rmh_out_t           median_q [$];
    int                 fail_cnt = 0;
    int                 idle_cycles = 0;

    function automatic bit outranks(bit is_max, logic signed [31:0] a,
                                    logic signed [31:0] b);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(bit is_max, logic signed [31:0] v);
        int k;
        int p;
        logic signed [31:0] t;
        k = is_max ? low_n : up_n;
        if (is_max)
        begin
            low_heap[k] = v;
            low_n++;
        end
        else
        begin
            up_heap[k] = v;
            up_n++;
        end
        while (k > 0)
        begin
            p = (k - 1) / 2;
            if (is_max)
            begin
                if (!outranks(1, low_heap[k], low_heap[p]))
                    break;
                t = low_heap[k]; low_heap[k] = low_heap[p]; low_heap[p] = t;
            end
            else
            begin
                if (!outranks(0, up_heap[k], up_heap[p]))
                    break;
                t = up_heap[k]; up_heap[k] = up_heap[p]; up_heap[p] = t;
            end
            k = p;
        end
    endtask

    task automatic heap_sink(bit is_max);
        int k;
        int best;
        int l;
        int r;
        int n;
        logic signed [31:0] t;
        k = 0;
        n = is_max ? low_n : up_n;
        forever
        begin
            best = k;
            l = 2 * k + 1;
            r = 2 * k + 2;
            if (is_max)
            begin
                if (l < n && outranks(1, low_heap[l], low_heap[best])) best = l;
                if (r < n && outranks(1, low_heap[r], low_heap[best])) best = r;
                if (best == k) break;
                t = low_heap[k]; low_heap[k] = low_heap[best]; low_heap[best] = t;
            end
            else
            begin
                if (l < n && outranks(0, up_heap[l], up_heap[best])) best = l;
                if (r < n && outranks(0, up_heap[r], up_heap[best])) best = r;
                if (best == k) break;
                t = up_heap[k]; up_heap[k] = up_heap[best]; up_heap[best] = t;
            end
            k = best;
        end
    endtask

    task automatic predict_median(rmh_in_t it);
        rmh_out_t exp_r;
        logic signed [31:0] x;
        logic signed [31:0] t;
        exp_r = '0;
        if (it.start_of_run)
        begin
            low_n = 0;
            up_n = 0;
            med_sum = '0;
            n_taken = 0;
        end
        if (n_taken >= MaxSamples)
            exp_r.full_dropped = 1'b1;
        else
        begin
            x = it.sample;
            if (low_n == 0 || x <= low_heap[0])
            begin
                if (low_n > up_n)
                begin
                    t = low_heap[0];
                    low_heap[0] = x;
                    heap_sink(1);
                    heap_insert(0, t);
                end
                else
                    heap_insert(1, x);
            end
            else if (up_n >= low_n)
            begin
                t = x;
                if (up_n > 0 && x > up_heap[0])
                begin
                    t = up_heap[0];
                    up_heap[0] = x;
                    heap_sink(0);
                end
                heap_insert(1, t);
            end
            else
                heap_insert(0, x);
            n_taken++;
            med_sum = med_sum + 64'(signed'(low_n > 0 ? low_heap[0] : 32'sd0));
        end
        exp_r.median       = low_n > 0 ? low_heap[0] : 32'sd0;
        exp_r.median_total = med_sum;
        exp_r.samples_seen = 11'(n_taken);
        median_q.push_back(exp_r);
    endtask

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            g = 0;
        repeat (g) @(posedge clk);
    endtask

    // one transfer on the command side
    task automatic send_sample(logic signed [31:0] v, logic sor);
        rmh_in_t it;
        it.sample = v;
        it.start_of_run = sor;
        start   <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_median(it);
        start <= 1'b0;
        // the block stays busy for at least this cycle after a transfer
        @(posedge clk);
        random_gap();
    endtask

    function automatic logic signed [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(int'($urandom_range(0, 20)) - 10);
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (median_q.size() == 0)
            begin
                $error("result with nothing pending");
                fail_cnt++;
            end
            else
            begin
                rmh_out_t e;
                e = median_q.pop_front();
                if (result.median !== e.median)
                begin
                    $error("median exp %0d got %0d", e.median, result.median);
                    fail_cnt++;
                end
                if (result.median_total !== e.median_total)
                begin
                    $error("median_total exp %0d got %0d", e.median_total,
                           result.median_total);
                    fail_cnt++;
                end
                if (result.samples_seen !== e.samples_seen)
                begin
                    $error("samples_seen exp %0d got %0d", e.samples_seen,
                           result.samples_seen);
                    fail_cnt++;
                end
                if (result.full_dropped !== e.full_dropped)
                begin
                    $error("full_dropped exp %0d got %0d", e.full_dropped,
                           result.full_dropped);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer or result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_edges();
        send_sample(32'sh7fffffff, 1'b1);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh7fffffff, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sd0, 1'b0);
        send_sample(-32'sd1, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd5, 1'b0);
        send_sample(32'sd3, 1'b1);
        send_sample(32'sd9, 1'b0);
        send_sample(32'sd7, 1'b0);
        send_sample(32'sd1, 1'b0);
        send_sample(32'sd8, 1'b0);
    endtask

    // fill to capacity, check drops, then restart while full
    task automatic test_capacity();
        send_sample(rand_sample(), 1'b1);
        for (int i = 1; i < MaxSamples; i++)
            send_sample(rand_sample(), 1'b0);
        send_sample(32'sd42, 1'b0);
        send_sample(32'sh80000000, 1'b0);
        send_sample(32'sd11, 1'b1);
    endtask

    task automatic test_random_runs();
        int runs;
        int len;
        runs = 0;
        while (runs < 60)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                              : $urandom_range(1, 12);
            send_sample(rand_sample(), 1'b1);
            for (int i = 1; i < len; i++)
                send_sample(rand_sample(), 1'b0);
            runs += len;
        end
    endtask

    initial
    begin
        start       = 1'b0;
        in_data     = '0;
        rst_n       = 1'b0;
        low_n = 0; up_n = 0; med_sum = '0; n_taken = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_capacity();
        test_random_runs();
        while (median_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_cnt == 0 && median_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
